/* rtl/msvr_pkg.sv */
// Package for the motor speed regulator: command codes, register indexes
// and shared widths. No dependencies.
`timescale 1ns / 1ps
package msvr_pkg;
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_RAMP   = 2'd1;
  localparam logic [1:0] CMD_ENABLE = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [2:0] REG_MIN_SPEED  = 3'd1;
  localparam logic [2:0] REG_IDLE_VOLT  = 3'd2;
  localparam logic [2:0] REG_MSV        = 3'd3;
  localparam logic [2:0] REG_BREAK_VOLT = 3'd4;
  localparam logic [2:0] REG_RAMP_UP    = 3'd5;
  localparam logic [2:0] REG_RAMP_DOWN  = 3'd6;

  localparam int CFG_W = 23;
  localparam int VW    = 24;   // drive level width
  localparam int FW    = 23;   // filter Q15.8 width
  localparam int KP    = 40;
  localparam int KI    = 2;
  localparam int BAND  = 30;

  typedef struct packed {
    logic [14:0] max_speed;
    logic [14:0] min_speed;
    logic [22:0] idle_volt;
    logic [22:0] min_speed_volt;
    logic [22:0] breakaway_volt;
    logic [15:0] ramp_up_step;
    logic [15:0] ramp_down_step;
  } cfg_t;
endpackage

/* rtl/motor_speed_voltage_regulator.sv */
// Top level of the DC motor speed regulator: command decode, tick sequencer,
// PI update and output register. Depends on msvr_pkg, msvr_serial_mul, msvr_serial_div.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tuser=cmd, tdata=target,ramp,enable,edges
//  m_axis  | out | m_axis_tvalid/tready | tdata=duty,volt,speed,target,written,running
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// Every word ends with the duty conversion: a serial multiply and a serial
// divide. Commands 0..2 and ignored ticks do only that; an enabled tick first
// adds the raw speed and the divide by five, two more divides, and may take
// the PI update as well.
// Reset is synchronous: sequencer, flags, filter, integral and drive clear, config to defaults.
// One word in flight: a new word is taken the cycle after the result is taken.
`timescale 1ns / 1ps
module motor_speed_voltage_regulator #(
  parameter int DUTY_BITS     = 10,
  parameter int FULL_SCALE_UV = 4720000,
  parameter int EDGES_PER_REV = 2,
  parameter int SAMPLE_MS     = 50,
  parameter int INTEGRAL_CAP  = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // target_speed, ramp_step, enable_flag, edge_count
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty, drive_volt, filtered_speed, active_target, duty_written, running
  output logic [((DUTY_BITS+56+7)/8)*8-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [msvr_pkg::CFG_W-1:0] cfg_data
);
  import msvr_pkg::*;
  localparam int OW   = ((DUTY_BITS + 56 + 7) / 8) * 8;
  localparam int MW   = 48;
  localparam int DIVW = SAMPLE_MS * EDGES_PER_REV;
  localparam logic [MW-1:0] TOPD = MW'((64'd1 << DUTY_BITS) - 64'd1);
  localparam int IW   = 17;

  localparam logic [3:0] S_IDLE = 4'd0, S_RAW = 4'd1, S_RAWW = 4'd2, S_FLT = 4'd3,
    S_FLTW = 4'd4, S_RULE = 4'd5, S_PI = 4'd6, S_PI2 = 4'd7, S_MUL = 4'd8,
    S_MULW = 4'd9, S_DUTY = 4'd10, S_DUTYW = 4'd11, S_OUT = 4'd12;

  cfg_t cfg;
  logic [3:0] state;
  logic enabled, motor_running, wrote;
  logic [14:0] target_hold;
  logic [VW-1:0] drive_level;
  logic [FW-1:0] filt;
  logic signed [IW-1:0] isum;
  logic [1:0]  cmd;
  logic [14:0] edges;
  logic signed [15:0] tgt_in, ramp_in;
  logic en_in;
  logic signed [33:0] tu;
  logic signed [IW-1:0] err;

  logic mul_start, mul_done, div_start, div_done;
  logic [MW-1:0] ma, mb, dn, dq;
  logic [95:0] mp;
  logic [MW-1:0] dd;

  msvr_serial_mul #(.AW(MW), .BW(MW)) u_mul (
    .clk, .rst, .start(mul_start), .a(ma), .b(mb), .done(mul_done), .prod(mp));
  msvr_serial_div #(.NW(MW), .DW(MW)) u_div (
    .clk, .rst, .start(div_start), .num(dn), .den(dd), .done(div_done), .quo(dq));

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{15'd3000, 15'd200, 23'd1000000, 23'd2000000, 23'd3300000, 16'd1000, 16'd2000};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SPEED:  cfg.max_speed      <= cfg_data[14:0];
        REG_MIN_SPEED:  cfg.min_speed      <= cfg_data[14:0];
        REG_IDLE_VOLT:  cfg.idle_volt      <= cfg_data;
        REG_MSV:        cfg.min_speed_volt <= cfg_data;
        REG_BREAK_VOLT: cfg.breakaway_volt <= cfg_data;
        REG_RAMP_UP:    cfg.ramp_up_step   <= cfg_data[15:0];
        REG_RAMP_DOWN:  cfg.ramp_down_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Registered start pulses for the serial units, set at the edge that loads their operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= (state == S_DUTY);
      div_start <= (state == S_RAW && cmd == CMD_TICK && enabled) ||
                   (state == S_RAWW && div_done) || (state == S_MULW && mul_done);
    end
  end

  // clamp helper results for target commands
  logic signed [17:0] tsel, lim;
  logic [14:0] tclamp;
  always_comb begin
    lim  = 18'(signed'({3'b0, target_hold})) + 18'(ramp_in);
    tsel = (cmd == CMD_RAMP && 18'(tgt_in) > lim) ? lim : 18'(tgt_in);
    if (tsel <= 0) tclamp = '0;
    else if (tsel > 18'(signed'({3'b0, cfg.max_speed}))) tclamp = cfg.max_speed;
    else tclamp = tsel[14:0];
  end

  // rule stage signals (all narrow compares on registered values)
  logic signed [25:0] cur, tq, half, minq;
  logic signed [25:0] uvs, ms, bv;
  logic moves;
  assign cur  = 26'(filt);
  assign tq   = 26'(target_hold) <<< 8;
  assign half = 26'(cfg.min_speed >> 1) <<< 8;
  assign minq = 26'(cfg.min_speed) <<< 8;
  assign uvs  = 26'(drive_level);
  assign ms   = 26'(cfg.min_speed_volt);
  assign bv   = 26'(cfg.breakaway_volt);
  assign moves = cur > half;

  logic signed [15:0] actual;
  always_comb begin
    actual = 16'(target_hold);
    if (target_hold < cfg.min_speed) actual = 16'(cfg.min_speed);
  end

  logic signed [IW-1:0] snew;
  always_comb begin
    snew = isum + err;
    if (snew > IW'(INTEGRAL_CAP)) snew = IW'(INTEGRAL_CAP);
    if (snew < -IW'(INTEGRAL_CAP)) snew = -IW'(INTEGRAL_CAP);
  end

  // PI output clamps: minimum-speed floor, breakaway cap, idle floor
  logic signed [33:0] tclip, idle_s;
  assign idle_s = 34'(signed'({1'b0, cfg.idle_volt}));
  always_comb begin
    tclip = tu;
    if (tu < 34'(ms) && actual <= 16'(cfg.min_speed)) tclip = 34'(ms);
    else if (tu > 34'(bv) && 34'(actual) > 34'(bv)) tclip = 34'(bv);
    else if (tu < idle_s) tclip = idle_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enabled <= 1'b0;
      motor_running <= 1'b0;
      target_hold <= '0;
      drive_level <= '0;
      filt <= '0;
      isum <= '0;
      m_axis_tvalid <= 1'b0;
      wrote <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd     <= s_axis_tuser;
          tgt_in  <= s_axis_tdata[15:0];
          ramp_in <= s_axis_tdata[31:16];
          en_in   <= s_axis_tdata[32];
          edges   <= s_axis_tdata[47:33];
          wrote   <= 1'b0;
          state   <= S_RAW;
        end
        S_RAW: begin
          unique case (cmd) inside
            CMD_SET, CMD_RAMP: begin
              target_hold <= tclamp;
              if (tsel > 0) enabled <= 1'b1;
              if (tclamp != 0) motor_running <= 1'b1;
              state <= S_DUTY;
            end
            CMD_ENABLE: begin
              enabled <= en_in;
              state <= S_DUTY;
            end
            default: begin
              if (!enabled) state <= S_DUTY;
              else begin
                // edges * 60000 * 256: a narrow product, then the fixed shift
                dn <= MW'({16'd0, edges} * 31'd60000) << 8;
                dd <= MW'(DIVW);
                state <= S_RAWW;
              end
            end
          endcase
        end
        S_RAWW: if (div_done) begin
          // saturate raw speed, then form 4*old + raw for the divide by five
          dn <= (MW'(filt) << 2) + ((dq > MW'(23'h7FFFFF)) ? MW'(23'h7FFFFF) : dq);
          dd <= MW'(5);
          state <= S_FLTW;
        end
        S_FLTW: if (div_done) begin
          filt <= dq[FW-1:0];
          state <= S_RULE;
        end
        S_RULE: begin
          if (target_hold == 0) begin
            if (motor_running) begin
              drive_level <= VW'(cfg.idle_volt);
              motor_running <= 1'b0;
              wrote <= 1'b1;
            end
            state <= S_DUTY;
          end else if (moves && cur > tq - (BAND <<< 8) && cur < tq + (BAND <<< 8)) begin
            state <= S_DUTY;
          end else begin
            wrote <= 1'b1;
            if (uvs < ms) begin
              drive_level <= VW'((27'(ms) + 27'(bv)) >> 1);
              state <= S_DUTY;
            end else if (target_hold > cfg.min_speed && uvs < bv) begin
              drive_level <= VW'(bv);
              state <= S_DUTY;
            end else if (target_hold <= cfg.min_speed) begin
              if (!moves && uvs < bv) begin
                tu <= 34'(uvs) + 34'(cfg.ramp_up_step);
                state <= S_PI;
              end else if (cur > minq + (BAND <<< 8) && uvs > bv) begin
                tu <= 34'(uvs) - 34'(cfg.ramp_down_step);
                state <= S_PI;
              end else begin
                state <= S_DUTY;
              end
            end else if (cur < tq) begin
              tu <= 34'(uvs) + 34'(cfg.ramp_up_step);
              state <= S_PI;
            end else if (uvs > ms) begin
              tu <= 34'(uvs) - 34'(cfg.ramp_down_step);
              state <= S_PI;
            end else begin
              state <= S_DUTY;
            end
          end
        end
        S_PI: begin
          err <= IW'(actual) - IW'(filt[FW-1:8]);
          state <= S_PI2;
        end
        S_PI2: begin
          isum <= snew;
          tu <= tu + 34'(err) * 34'(KP) + 34'(snew) * 34'(KI);
          state <= S_MUL;
        end
        S_MUL: begin
          if (tclip < 0) drive_level <= '0;
          else if (tclip > 34'sd16777215) drive_level <= '1;
          else drive_level <= tclip[VW-1:0];
          state <= S_DUTY;
        end
        S_DUTY: begin
          ma <= MW'(drive_level);
          mb <= TOPD;
          state <= S_MULW;
        end
        S_MULW: if (mul_done) begin
          dn <= mp[MW-1:0];
          dd <= MW'(FULL_SCALE_UV);
          state <= S_DUTYW;
        end
        S_DUTYW: if (div_done) begin
          m_axis_tdata <= OW'({enabled, wrote, target_hold, filt[FW-1:8], drive_level,
            (drive_level >= VW'(FULL_SCALE_UV)) ? TOPD[DUTY_BITS-1:0] : dq[DUTY_BITS-1:0]});
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid) else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> state == S_IDLE)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) isum <= IW'(INTEGRAL_CAP)
    && isum >= -IW'(INTEGRAL_CAP)) else $error("integral out of range");
endmodule

/* rtl/msvr_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on msvr_pkg.
`timescale 1ns / 1ps
module msvr_serial_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  import msvr_pkg::*;
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [NW-1:0] sh;
  logic [DW-1:0] dreg;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], sh[NW-1]};
  assign quo = sh;

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      sh   <= num;
      dreg <= den;
      rem  <= '0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      // shift one numerator bit in, subtract when it fits
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        sh  <= {sh[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        sh  <= {sh[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

/* rtl/msvr_serial_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on msvr_pkg.
`timescale 1ns / 1ps
module msvr_serial_mul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  import msvr_pkg::*;
  localparam int CW = $clog2(BW + 1);
  logic [CW-1:0]    cnt;
  logic [AW+BW-1:0] acc_a;
  logic [BW-1:0]    sb;
  logic             busy;

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      acc_a <= (AW+BW)'(a);
      sb    <= b;
      prod  <= '0;
      cnt   <= CW'(BW);
    end else if (busy) begin
      if (sb[0]) prod <= prod + acc_a;
      acc_a <= acc_a << 1;
      sb    <= sb >> 1;
      cnt   <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for motor_speed_voltage_regulator: directed table, then
// random command streams checked against a built-in speed/voltage predictor.
// Depends on msvr_pkg and the regulator RTL.
`timescale 1ns / 1ps
module testbench;
  import msvr_pkg::*;

  localparam int DUTY_BITS = 10;
  localparam int FULL_SCALE_UV = 4720000;
  localparam int EDGES_PER_REV = 2;
  localparam int SAMPLE_MS = 50;
  localparam int INTEGRAL_CAP = 1000;
  localparam int MW = ((DUTY_BITS + 56 + 7) / 8) * 8;
  localparam longint FILT_MAX = 8388607;
  localparam longint VOLT_MAX = 16777215;

  typedef struct {
    logic [9:0]  duty;
    logic [23:0] volt;
    logic [14:0] speed;
    logic [14:0] target;
    logic        written;
    logic        running;
  } motor_status_t;

  typedef struct {
    logic [1:0]    cmd;
    logic [15:0]   target;
    logic [15:0]   ramp;
    logic          en;
    logic [14:0]   edges;
    bit            typed;
    motor_status_t status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = CMD_SET;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [MW-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_MAX_SPEED;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  motor_speed_voltage_regulator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the configuration registers, reset values first.
  longint max_speed_r = 3000, min_speed_r = 200, idle_volt_r = 1000000;
  longint msv_r = 2000000, break_volt_r = 3300000, ramp_up_r = 1000, ramp_down_r = 2000;

  // Mirror of the regulator state.
  bit     en_st, moving_st;
  longint target_st, drive_st, filt_st, integ_st;

  motor_status_t status_q[$];
  int  mismatches = 0;
  bit  calm = 1'b0;           // no random idling on either side while set
  int  hold_req = 0;          // bump to make the receiver hold off
  bit  cur_typed = 1'b0;      // current word carries a typed expectation
  motor_status_t cur_status;

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic void apply_target(longint t);
    if (t > 0) en_st = 1'b1;
    if (t <= 0) t = 0;
    else if (t > max_speed_r) t = max_speed_r;
    if (t > 0) moving_st = 1'b1;
    target_st = t;
  endfunction

  // Advance the mirrored state by one command word and return its status word.
  function automatic motor_status_t predict_status(logic [1:0] cmd, logic [47:0] d);
    longint lim, raw, cur, tgt, uv, act, err, s, tu;
    bit moves, pid, wrote;
    motor_status_t r;
    wrote = 1'b0;
    pid = 1'b0;
    case (cmd)
      CMD_SET: apply_target(sext16(d[15:0]));
      CMD_RAMP: begin
        lim = target_st + sext16(d[31:16]);
        apply_target(sext16(d[15:0]) > lim ? lim : sext16(d[15:0]));
      end
      CMD_ENABLE: en_st = d[32];
      default: begin
        if (en_st) begin
          raw = (longint'(d[47:33]) * 60000 * 256) / (SAMPLE_MS * EDGES_PER_REV);
          if (raw > FILT_MAX) raw = FILT_MAX;
          filt_st = (filt_st * 4 + raw) / 5;
          tgt = target_st;
          if (tgt == 0) begin
            // zero target: park at idle once, then stay silent
            if (moving_st) begin
              drive_st = idle_volt_r;
              moving_st = 1'b0;
              wrote = 1'b1;
            end
          end else begin
            cur = filt_st;
            moves = cur > (min_speed_r / 2) * 256;
            uv = drive_st;
            if (!(moves && cur > (tgt - BAND) * 256 && cur < (tgt + BAND) * 256)) begin
              wrote = 1'b1;
              if (uv < msv_r) begin
                uv = (msv_r + break_volt_r) / 2;
              end else if (tgt > min_speed_r && uv < break_volt_r) begin
                uv = break_volt_r;
              end else if (tgt <= min_speed_r) begin
                if (!moves && uv < break_volt_r) begin
                  uv += ramp_up_r;
                  pid = 1'b1;
                end else if (cur > (min_speed_r + BAND) * 256 && uv > break_volt_r) begin
                  uv -= ramp_down_r;
                  pid = 1'b1;
                end
              end else if (cur < tgt * 256) begin
                uv += ramp_up_r;
                pid = 1'b1;
              end else if (uv > msv_r) begin
                uv -= ramp_down_r;
                pid = 1'b1;
              end
              if (pid) begin
                act = tgt;
                if (act > 0 && act < min_speed_r) act = min_speed_r;
                err = act - (cur >>> 8);
                s = integ_st + err;
                if (s > INTEGRAL_CAP) s = INTEGRAL_CAP;
                if (s < -INTEGRAL_CAP) s = -INTEGRAL_CAP;
                integ_st = s;
                // target rpm compared against breakaway volts, as specified
                tu = uv + KP * err + KI * integ_st;
                if (tu < msv_r && act <= min_speed_r) tu = msv_r;
                else if (tu > break_volt_r && act > break_volt_r) tu = break_volt_r;
                else if (tu < idle_volt_r) tu = idle_volt_r;
                uv = tu;
              end
              if (uv < 0) uv = 0;
              if (uv > VOLT_MAX) uv = VOLT_MAX;
              drive_st = uv;
            end
          end
        end
      end
    endcase
    r.duty = (drive_st >= FULL_SCALE_UV) ? 10'd1023
             : 10'((drive_st * 1023) / FULL_SCALE_UV);
    r.volt = 24'(drive_st);
    r.speed = 15'(filt_st >> 8);
    r.target = 15'(target_st);
    r.written = wrote;
    r.running = en_st;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got, ref bit bad);
    if (want != got) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("mismatch %s: expected %0d actual %0d at %0t", name, want, got, $realtime);
    end
  endtask

  // Monitor: predict on every accepted input word, check every accepted output word.
  always @(posedge clk) begin
    motor_status_t want, got, pred;
    bit bad;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pred = predict_status(s_axis_tuser, s_axis_tdata);
      status_q.push_back(cur_typed ? cur_status : pred);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.duty = m_axis_tdata[9:0];
      got.volt = m_axis_tdata[33:10];
      got.speed = m_axis_tdata[48:34];
      got.target = m_axis_tdata[63:49];
      got.written = m_axis_tdata[64];
      got.running = m_axis_tdata[65];
      if (status_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected output word at %0t", $realtime);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        bad = 1'b0;
        check_field("duty", want.duty, got.duty, bad);
        check_field("drive_volt", want.volt, got.volt, bad);
        check_field("filtered_speed", want.speed, got.speed, bad);
        check_field("active_target", want.target, got.target, bad);
        check_field("duty_written", want.written, got.written, bad);
        check_field("running", want.running, got.running, bad);
        if (bad) mismatches++;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    int hold_cnt, hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Offer one word and hold it until accepted; valid stays high into the next word unless a random idle gap drops it.
  task automatic send_word(stim_row_t row);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.cmd;
    s_axis_tdata <= {row.edges, row.en, row.ramp, row.target};
    cur_typed <= row.typed;
    cur_status <= row.status;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED:  max_speed_r = value & 'h7FFF;
      REG_MIN_SPEED:  min_speed_r = value & 'h7FFF;
      REG_IDLE_VOLT:  idle_volt_r = value & 'h7FFFFF;
      REG_MSV:        msv_r = value & 'h7FFFFF;
      REG_BREAK_VOLT: break_volt_r = value & 'h7FFFFF;
      REG_RAMP_UP:    ramp_up_r = value & 'hFFFF;
      default:        ramp_down_r = value & 'hFFFF;
    endcase
  endtask

  function automatic stim_row_t row_of(logic [1:0] c, int tg, int rp, bit e, int ed);
    stim_row_t r;
    r.cmd = c;
    r.target = 16'(tg);
    r.ramp = 16'(rp);
    r.en = e;
    r.edges = 15'(ed);
    r.typed = 1'b0;
    r.status = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t r, int tg, bit run);
    r.typed = 1'b1;
    r.status = '{duty: 0, volt: 0, speed: 0, target: 15'(tg), written: 0, running: run};
    return r;
  endfunction

  function automatic stim_row_t random_row();
    int pick;
    stim_row_t r;
    pick = $urandom_range(99);
    r = row_of(CMD_TICK, 0, 0, 0, 0);
    // random upper bits everywhere so every input bit toggles
    r.target = 16'($urandom);
    r.ramp = 16'($urandom);
    r.en = 1'($urandom);
    r.edges = 15'($urandom);
    if (pick < 12) begin
      r.cmd = CMD_SET;
      if ($urandom_range(3) != 0) r.target = 16'($urandom_range(4000));
    end else if (pick < 20) begin
      r.cmd = CMD_RAMP;
      if ($urandom_range(3) != 0) begin
        r.target = 16'($urandom_range(4000));
        r.ramp = 16'($signed($urandom_range(1000)) - 300);
      end
    end else if (pick < 28) begin
      r.cmd = CMD_ENABLE;
      if ($urandom_range(3) != 0) r.en = 1'b1;
    end else begin
      // ticks: mostly small edge counts around realistic speeds
      if ($urandom_range(9) != 0) r.edges = 15'($urandom_range(8));
    end
    return r;
  endfunction

  stim_row_t directed[$];

  initial begin
    directed = '{
      typed_row(row_of(CMD_TICK, 0, 0, 0, 0), 0, 0),          // tick while disabled
      typed_row(row_of(CMD_ENABLE, 0, 0, 1, 0), 0, 1),
      typed_row(row_of(CMD_TICK, 0, 0, 0, 0), 0, 1),          // zero target, not moving
      typed_row(row_of(CMD_SET, 32767, 0, 0, 0), 3000, 1),    // clamp to max
      row_of(CMD_TICK, 0, 0, 0, 3),
      row_of(CMD_TICK, 0, 0, 0, 5),
      row_of(CMD_TICK, 0, 0, 0, 32767),                       // raw speed saturates
      row_of(CMD_TICK, 0, 0, 0, 32767),
      row_of(CMD_TICK, 0, 0, 0, 5),                           // deadband region
      row_of(CMD_RAMP, 32767, 32767, 0, 0),
      row_of(CMD_RAMP, 32767, -32768, 0, 0),                  // ramp sum below zero
      row_of(CMD_TICK, 0, 0, 1, 0),                           // zero target while moving
      row_of(CMD_TICK, 0, 0, 0, 0),
      row_of(CMD_SET, 150, 0, 0, 0),                          // target under min speed
      row_of(CMD_TICK, 0, 0, 0, 0),
      row_of(CMD_TICK, 0, 0, 0, 1),
      row_of(CMD_TICK, 0, 0, 0, 1),
      row_of(CMD_SET, -32768, 0, 0, 0),
      row_of(CMD_SET, 1, 0, 0, 0),
      row_of(CMD_RAMP, 2500, 100, 0, 0),
      row_of(CMD_TICK, 0, 0, 0, 2),
      row_of(CMD_ENABLE, 0, 0, 0, 0),
      row_of(CMD_TICK, 0, 0, 0, 7),                           // ignored while disabled
      row_of(CMD_ENABLE, 16'hFFFF, 16'hFFFF, 1, 32767)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      // reprogram only while idle
      case (phase)
        0: begin
          write_reg(REG_MAX_SPEED, 32767); write_reg(REG_MIN_SPEED, 32767);
          write_reg(REG_IDLE_VOLT, 4720000); write_reg(REG_MSV, 4720000);
          write_reg(REG_BREAK_VOLT, 4720000); write_reg(REG_RAMP_UP, 65535);
          write_reg(REG_RAMP_DOWN, 65535);
        end
        1: begin
          write_reg(REG_MAX_SPEED, 0); write_reg(REG_MIN_SPEED, 0);
          write_reg(REG_IDLE_VOLT, 0); write_reg(REG_MSV, 0);
          write_reg(REG_BREAK_VOLT, 0); write_reg(REG_RAMP_UP, 0);
          write_reg(REG_RAMP_DOWN, 0);
        end
        2: begin
          write_reg(REG_MAX_SPEED, $urandom_range(32767));
          write_reg(REG_MIN_SPEED, $urandom_range(32767));
          write_reg(REG_IDLE_VOLT, $urandom_range(4720000));
          write_reg(REG_MSV, $urandom_range(4720000));
          write_reg(REG_BREAK_VOLT, $urandom_range(4720000));
          write_reg(REG_RAMP_UP, $urandom_range(65535));
          write_reg(REG_RAMP_DOWN, $urandom_range(65535));
        end
        default: begin
          write_reg(REG_MAX_SPEED, 3000 + $urandom_range(3000));
          write_reg(REG_MIN_SPEED, 100 + $urandom_range(1500));
          write_reg(REG_IDLE_VOLT, 1000000); write_reg(REG_MSV, 2000000);
          write_reg(REG_BREAK_VOLT, 3300000 + $urandom_range(1000000));
          write_reg(REG_RAMP_UP, $urandom_range(20000));
          write_reg(REG_RAMP_DOWN, $urandom_range(20000));
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < 165; n++) begin
        if (phase == 3 && n == 20) hold_req++;       // long stall on the output
        calm = (phase == 4 && n >= 40 && n < 110);
        if (phase == 2 && n == 80) drain();          // sender waits for all results
        send_word(random_row());
      end
      calm = 1'b0;
      drain();
    end

    for (int w = 0; w < 200 && status_q.size() != 0; w++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("PASS motor_speed_voltage_regulator");
    end else begin
      $display("FAIL motor_speed_voltage_regulator");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL motor_speed_voltage_regulator");
    $finish;
  end
endmodule

/* files.f */
rtl/msvr_pkg.sv
rtl/msvr_serial_div.sv
rtl/msvr_serial_mul.sv
rtl/motor_speed_voltage_regulator.sv
tb/sv/testbench.sv
